FILE: rtl/core/particle_cell_list_macros.svh
// Assertion macros for the property checker of this block.
`ifndef PARTICLE_CELL_LIST_MACROS_SVH
`define PARTICLE_CELL_LIST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("particle_cell_list assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PCL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("particle_cell_list assertion failed");

`endif

FILE: rtl/core/pcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcl_pkg;

  localparam int MAX_CELLS      = 4096;
  localparam int SLOTS_PER_CELL = 8;
  localparam int MAX_PARTICLES  = 4096;
  localparam int MAX_EMIT       = 64;

  localparam int CELL_W  = $clog2(MAX_CELLS);
  localparam int PID_AW  = $clog2(MAX_PARTICLES);
  localparam int SIDX_W  = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
  localparam int ID_W    = 12;
  localparam int SLOT_W  = ID_W + 1;
  localparam int LIN_W   = 40;
  localparam int CXY_W   = 26;
  localparam int TOT_W   = 8;
  localparam int CLR_W   = $clog2(((MAX_CELLS > MAX_PARTICLES) ? MAX_CELLS : MAX_PARTICLES) + 1);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef slot_t [SLOTS_PER_CELL-1:0] row_t;
  typedef logic [CELL_W:0] home_t;

  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] addr;
    row_t              data;
  } row_wr_t;

  typedef struct packed {
    logic              en;
    logic [PID_AW-1:0] addr;
    home_t             data;
  } home_wr_t;

  typedef struct packed {
    logic             done;
    logic             ok;
    logic [11:0]      ci;
    logic [11:0]      cj;
    logic [11:0]      ck;
    logic [LIN_W-1:0] lin;
  } map_res_t;

  typedef enum logic [2:0] {
    STS_MOVED = 3'd0,
    STS_SAME  = 3'd1,
    STS_OUT   = 3'd2,
    STS_FULL  = 3'd3,
    STS_NBR   = 3'd4,
    STS_NONE  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_INV_LEN  = 3'd3,
    CFG_CELLS_X  = 3'd4,
    CFG_CELLS_Y  = 3'd5,
    CFG_CELLS_Z  = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_LOAD,
    MS_MUL,
    MS_USE,
    MS_SUM,
    MS_DONE
  } map_st_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_HOME,
    ST_OLD,
    ST_NEW,
    ST_GRD,
    ST_GCNT,
    ST_GEMIT,
    ST_RESP
  } ctl_st_t;

endpackage
`default_nettype wire

FILE: rtl/core/pcl_store.sv
`timescale 1ns / 1ps
`default_nettype none
module pcl_store (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      row_rd_en,
  input  wire logic [pcl_pkg::CELL_W-1:0] row_rd_addr,
  output pcl_pkg::row_t                  row_rd_data,
  input  pcl_pkg::row_wr_t               row_wr,
  input  wire logic                      home_rd_en,
  input  wire logic [pcl_pkg::PID_AW-1:0] home_rd_addr,
  output pcl_pkg::home_t                 home_rd_data,
  input  pcl_pkg::home_wr_t              home_wr,
  output logic                           clr_busy
);
  import pcl_pkg::*;

  row_t  rows  [MAX_CELLS];
  home_t homes [MAX_PARTICLES];

  logic [CLR_W-1:0] clr_r;
  logic [CLR_W-1:0] clr_nxt;
  logic             clr_act_r;
  logic             clr_act_nxt;

  always_comb begin
    clr_nxt     = clr_r;
    clr_act_nxt = clr_act_r;
    if (clr_act_r) begin
      clr_nxt = clr_r + CLR_W'(1);
      if (clr_r == CLR_W'((MAX_CELLS > MAX_PARTICLES) ? MAX_CELLS - 1 : MAX_PARTICLES - 1)) begin
        clr_act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      clr_act_r <= 1'b1;
    end else begin
      clr_r     <= clr_nxt;
      clr_act_r <= clr_act_nxt;
    end
  end

  assign clr_busy = clr_act_r;

  // The sweep zeroes one row and one home entry per cycle after reset.
  always_ff @(posedge clk) begin
    if (clr_act_r) begin
      if (clr_r < CLR_W'(MAX_CELLS)) begin
        rows[clr_r[CELL_W-1:0]] <= '0;
      end
    end else if (row_wr.en) begin
      rows[row_wr.addr] <= row_wr.data;
    end
    if (row_rd_en) begin
      row_rd_data <= rows[row_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_act_r) begin
      if (clr_r < CLR_W'(MAX_PARTICLES)) begin
        homes[clr_r[PID_AW-1:0]] <= '0;
      end
    end else if (home_wr.en) begin
      homes[home_wr.addr] <= home_wr.data;
    end
    if (home_rd_en) begin
      home_rd_data <= homes[home_rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/pcl_cellmap.sv
`timescale 1ns / 1ps
`default_nettype none
module pcl_cellmap (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        gather,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] pos_z,
  input  wire logic [11:0] q_i,
  input  wire logic [11:0] q_j,
  input  wire logic [11:0] q_k,
  input  wire logic [31:0] origin_x,
  input  wire logic [31:0] origin_y,
  input  wire logic [31:0] origin_z,
  input  wire logic [31:0] inv_len,
  input  wire logic [12:0] cells_x,
  input  wire logic [12:0] cells_y,
  input  wire logic [12:0] cells_z,
  output pcl_pkg::map_res_t res
);
  import pcl_pkg::*;

  map_st_t state_r;
  map_st_t state_nxt;

  logic [2:0]       step_r;
  logic             gather_r;
  logic [64:0]      prod_r;
  logic             neg_r;
  logic             ok_r;
  logic [11:0]      ci_r;
  logic [11:0]      cj_r;
  logic [11:0]      ck_r;
  logic [24:0]      jx_r;
  logic [CXY_W-1:0] cxy_r;
  logic [37:0]      kc_r;
  logic [LIN_W-1:0] lin_r;

  logic [31:0] pos_sel;
  logic [31:0] org_sel;
  logic [12:0] cells_sel;
  logic [33:0] diff;
  logic [33:0] mag;
  logic [32:0] a_op;
  logic [31:0] b_op;
  logic [32:0] ip;
  logic [11:0] c_axis;
  logic        ok_axis;

  always_comb begin
    pos_sel   = pos_x;
    org_sel   = origin_x;
    cells_sel = cells_x;
    case (step_r)
      3'd1: begin
        pos_sel   = pos_y;
        org_sel   = origin_y;
        cells_sel = cells_y;
      end
      3'd2: begin
        pos_sel   = pos_z;
        org_sel   = origin_z;
        cells_sel = cells_z;
      end
      default: begin
        pos_sel   = pos_x;
        org_sel   = origin_x;
        cells_sel = cells_x;
      end
    endcase
    diff = {{2{pos_sel[31]}}, pos_sel} - {{2{org_sel[31]}}, org_sel};
    mag  = diff[33] ? (34'd0 - diff) : diff;
    case (step_r)
      3'd3: begin
        a_op = 33'(cj_r);
        b_op = 32'(cells_x);
      end
      3'd4: begin
        a_op = 33'(cells_x);
        b_op = 32'(cells_y);
      end
      3'd5: begin
        a_op = 33'(ck_r);
        b_op = 32'(cxy_r);
      end
      default: begin
        a_op = mag[32:0];
        b_op = inv_len;
      end
    endcase
    // Truncation toward zero: a negative offset lands in cell 1 or 0 only.
    ip = prod_r[64:32];
    if (neg_r) begin
      ok_axis = (ip <= 33'd1);
      c_axis  = (ip == 33'd0) ? 12'd1 : 12'd0;
    end else begin
      ok_axis = (ip < 33'd4095);
      c_axis  = ip[11:0] + 12'd1;
    end
    ok_axis = ok_axis && ({1'b0, c_axis} < cells_sel);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MS_IDLE: if (start) state_nxt = MS_LOAD;
      MS_LOAD: state_nxt = MS_MUL;
      MS_MUL:  state_nxt = MS_USE;
      MS_USE:  state_nxt = (step_r == 3'd5) ? MS_SUM : MS_MUL;
      MS_SUM:  state_nxt = MS_DONE;
      MS_DONE: state_nxt = MS_IDLE;
      default: state_nxt = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      MS_IDLE: begin
        if (start) begin
          gather_r <= gather;
          step_r   <= gather ? 3'd3 : 3'd0;
          ok_r     <= 1'b1;
        end
      end
      MS_LOAD: begin
        if (gather_r) begin
          ci_r <= q_i;
          cj_r <= q_j;
          ck_r <= q_k;
        end
      end
      MS_MUL: begin
        prod_r <= 65'(a_op * b_op);
        neg_r  <= diff[33];
      end
      MS_USE: begin
        case (step_r)
          3'd0: begin ci_r <= c_axis; ok_r <= ok_r & ok_axis; end
          3'd1: begin cj_r <= c_axis; ok_r <= ok_r & ok_axis; end
          3'd2: begin ck_r <= c_axis; ok_r <= ok_r & ok_axis; end
          3'd3: jx_r  <= prod_r[24:0];
          3'd4: cxy_r <= prod_r[CXY_W-1:0];
          default: kc_r <= prod_r[37:0];
        endcase
        step_r <= step_r + 3'd1;
      end
      MS_SUM: begin
        lin_r <= LIN_W'(ci_r) + LIN_W'(jx_r) + LIN_W'(kc_r);
      end
      default: begin
      end
    endcase
  end

  assign res.done = (state_r == MS_DONE);
  assign res.ok   = ok_r;
  assign res.ci   = ci_r;
  assign res.cj   = cj_r;
  assign res.ck   = ck_r;
  assign res.lin  = lin_r;

endmodule
`default_nettype wire

FILE: rtl/core/particle_cell_list.sv
// Update: from input transfer to result, cell mapping through one shared 33x32
// multiplier, then a home read and up to two row read-modify-writes.
// Gather: cell mapping, then up to two walks of the 27 neighbor rows; a row outside
// the grid is skipped without a read, and result stalls hold the second walk.
// One item is in work at a time. After reset a sweep clears the slot and
// home memories; no input transfer is taken during it, configuration writes are.
`timescale 1ns / 1ps
`default_nettype none
module particle_cell_list (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // particle_id[11:0], pos_x[43:12], pos_y[75:44], pos_z[107:76],
  // query_i[119:108], query_j[131:120], query_k[143:132]
  input  wire logic [143:0] in_tdata,
  // command
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // result_id[11:0], cell_i[23:12], cell_j[35:24], cell_k[47:36],
  // neighbour_total[55:48], truncated[56], zero fill[63:57]
  output logic [63:0]       out_tdata,
  // status
  output logic [2:0]        out_tuser,
  output logic              out_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import pcl_pkg::*;

  logic [31:0] origin_x_r, origin_y_r, origin_z_r, inv_len_r;
  logic [12:0] cells_x_r, cells_y_r, cells_z_r;

  logic        cmd_r;
  logic [11:0] pid_r;
  logic [31:0] px_r, py_r, pz_r;
  logic [11:0] qi_r, qj_r, qk_r;

  ctl_st_t state_r, state_nxt;
  logic [1:0]        d_i_r, d_i_nxt, d_j_r, d_j_nxt, d_k_r, d_k_nxt;
  logic              pass_r, pass_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [TOT_W-1:0]  emit_n_r, emit_n_nxt;
  logic [SIDX_W-1:0] s_r, s_nxt;
  status_t           resp_sts_r, resp_sts_nxt;
  logic              resp_cell_r, resp_cell_nxt;

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [2:0]  out_user_r;
  logic        out_last_r;

  logic              accept;
  logic              out_free;
  logic              push;
  status_t           push_sts;
  logic [11:0]       push_id;
  logic              push_cell;
  logic              push_gat;
  logic              push_last;

  logic              map_start;
  map_res_t          map_res;

  logic              row_rd_en;
  logic [CELL_W-1:0] row_rd_addr;
  row_t              row_rd_data;
  row_wr_t           row_wr;
  logic              home_rd_en;
  home_t             home_rd_data;
  home_wr_t          home_wr;
  logic              clr_busy;

  logic [13:0]       ni, nj, nk;
  logic              ok_i, ok_j, ok_k, nb_ok, nb_end, do_adv;
  logic signed [41:0] nb_lin;
  logic signed [41:0] off_i, off_j, off_k;
  logic signed [41:0] cx_s, cxy_s;
  logic [1:0]        inc_i, inc_j, inc_k;
  logic [TOT_W-1:0]  emit_lim;
  logic [TOT_W:0]    tot_sum;
  logic              trunc;
  logic              hv;
  logic [CELL_W-1:0] hc;
  logic [CELL_W-1:0] lin_a;
  logic              lin_bad;
  row_t              row_mod;
  logic              present;
  logic              free_found;
  logic [SIDX_W-1:0] free_idx;
  slot_t             cur_slot;
  slot_t             my_slot;

  function automatic logic [SIDX_W:0] pop_row(input row_t r);
    logic [SIDX_W:0] n;
    n = '0;
    for (int s = 0; s < SLOTS_PER_CELL; s++) begin
      n = n + (SIDX_W + 1)'(r[s][ID_W]);
    end
    return n;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      inv_len_r  <= 32'd65536;
      cells_x_r  <= 13'd1;
      cells_y_r  <= 13'd1;
      cells_z_r  <= 13'd1;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X: origin_x_r <= cfg_data;
        CFG_ORIGIN_Y: origin_y_r <= cfg_data;
        CFG_ORIGIN_Z: origin_z_r <= cfg_data;
        CFG_INV_LEN:  inv_len_r  <= cfg_data;
        CFG_CELLS_X:  cells_x_r  <= cfg_data[12:0];
        CFG_CELLS_Y:  cells_y_r  <= cfg_data[12:0];
        CFG_CELLS_Z:  cells_z_r  <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  assign in_tready = (state_r == ST_IDLE) && !clr_busy;
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign map_start = accept;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_tuser;
      pid_r <= in_tdata[11:0];
      px_r  <= in_tdata[43:12];
      py_r  <= in_tdata[75:44];
      pz_r  <= in_tdata[107:76];
      qi_r  <= in_tdata[119:108];
      qj_r  <= in_tdata[131:120];
      qk_r  <= in_tdata[143:132];
    end
  end

  pcl_cellmap u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (map_start),
    .gather   (in_tuser),
    .pos_x    (px_r),
    .pos_y    (py_r),
    .pos_z    (pz_r),
    .q_i      (qi_r),
    .q_j      (qj_r),
    .q_k      (qk_r),
    .origin_x (origin_x_r),
    .origin_y (origin_y_r),
    .origin_z (origin_z_r),
    .inv_len  (inv_len_r),
    .cells_x  (cells_x_r),
    .cells_y  (cells_y_r),
    .cells_z  (cells_z_r),
    .res      (map_res)
  );

  pcl_store u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .row_rd_en    (row_rd_en),
    .row_rd_addr  (row_rd_addr),
    .row_rd_data  (row_rd_data),
    .row_wr       (row_wr),
    .home_rd_en   (home_rd_en),
    .home_rd_addr (pid_r[PID_AW-1:0]),
    .home_rd_data (home_rd_data),
    .home_wr      (home_wr),
    .clr_busy     (clr_busy)
  );

  // Neighbor cell of the gather walk and its linear number.
  always_comb begin
    ni    = {2'b00, qi_r} + {12'd0, d_i_r} - 14'd1;
    nj    = {2'b00, qj_r} + {12'd0, d_j_r} - 14'd1;
    nk    = {2'b00, qk_r} + {12'd0, d_k_r} - 14'd1;
    ok_i  = !ni[13] && !ni[12] && (ni[12:0] < cells_x_r);
    ok_j  = !nj[13] && !nj[12] && (nj[12:0] < cells_y_r);
    ok_k  = !nk[13] && !nk[12] && (nk[12:0] < cells_z_r);
    cx_s  = $signed(42'(cells_x_r));
    cxy_s = $signed(42'(u_map.cxy_r));
    off_i = (d_i_r == 2'd0) ? -42'sd1 : ((d_i_r == 2'd2) ? 42'sd1 : 42'sd0);
    off_j = (d_j_r == 2'd0) ? -cx_s : ((d_j_r == 2'd2) ? cx_s : 42'sd0);
    off_k = (d_k_r == 2'd0) ? -cxy_s : ((d_k_r == 2'd2) ? cxy_s : 42'sd0);
    nb_lin = $signed({2'b00, map_res.lin}) + off_i + off_j + off_k;
    nb_ok  = ok_i && ok_j && ok_k && !nb_lin[41] && (nb_lin < 42'(MAX_CELLS));
    nb_end = (d_i_r == 2'd2) && (d_j_r == 2'd2) && (d_k_r == 2'd2);
    inc_i  = (d_i_r == 2'd2) ? 2'd0 : d_i_r + 2'd1;
    inc_j  = (d_i_r == 2'd2) ? ((d_j_r == 2'd2) ? 2'd0 : d_j_r + 2'd1) : d_j_r;
    inc_k  = ((d_i_r == 2'd2) && (d_j_r == 2'd2)) ?
             ((d_k_r == 2'd2) ? 2'd0 : d_k_r + 2'd1) : d_k_r;
    emit_lim = (total_r > TOT_W'(MAX_EMIT)) ? TOT_W'(MAX_EMIT) : total_r;
    trunc    = (total_r > TOT_W'(MAX_EMIT));
    tot_sum  = {1'b0, total_r} + (TOT_W + 1)'(pop_row(row_rd_data));
  end

  // Update helpers: home entry, slot match and first free slot.
  always_comb begin
    hv       = home_rd_data[CELL_W];
    hc       = home_rd_data[CELL_W-1:0];
    lin_a    = map_res.lin[CELL_W-1:0];
    lin_bad  = !map_res.ok || (map_res.lin >= LIN_W'(MAX_CELLS)) ||
               (32'(pid_r) >= 32'(MAX_PARTICLES));
    my_slot  = {1'b1, pid_r};
    row_mod  = row_rd_data;
    present  = 1'b0;
    free_found = 1'b0;
    free_idx = '0;
    for (int s = 0; s < SLOTS_PER_CELL; s++) begin
      if (row_rd_data[s] == my_slot) begin
        row_mod[s] = '0;
        present    = 1'b1;
      end
      if (!row_rd_data[s][ID_W] && !free_found) begin
        free_found = 1'b1;
        free_idx   = SIDX_W'(s);
      end
    end
    cur_slot = row_rd_data[s_r];
  end

  always_comb begin
    state_nxt     = state_r;
    d_i_nxt       = d_i_r;
    d_j_nxt       = d_j_r;
    d_k_nxt       = d_k_r;
    pass_nxt      = pass_r;
    total_nxt     = total_r;
    emit_n_nxt    = emit_n_r;
    s_nxt         = s_r;
    resp_sts_nxt  = resp_sts_r;
    resp_cell_nxt = resp_cell_r;
    row_rd_en     = 1'b0;
    row_rd_addr   = lin_a;
    row_wr        = '0;
    home_rd_en    = 1'b0;
    home_wr       = '0;
    push          = 1'b0;
    push_sts      = resp_sts_r;
    push_id       = '0;
    push_cell     = 1'b0;
    push_gat      = 1'b0;
    push_last     = 1'b1;
    do_adv        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_MAP;
      end
      ST_MAP: begin
        if (map_res.done) begin
          if (cmd_r) begin
            d_i_nxt    = 2'd0;
            d_j_nxt    = 2'd0;
            d_k_nxt    = 2'd0;
            pass_nxt   = 1'b0;
            total_nxt  = '0;
            emit_n_nxt = '0;
            state_nxt  = ST_GRD;
          end else if (lin_bad) begin
            resp_sts_nxt  = STS_OUT;
            resp_cell_nxt = 1'b0;
            state_nxt     = ST_RESP;
          end else begin
            home_rd_en = 1'b1;
            state_nxt  = ST_HOME;
          end
        end
      end
      ST_HOME: begin
        if (hv && (hc == lin_a)) begin
          resp_sts_nxt  = STS_SAME;
          resp_cell_nxt = 1'b1;
          state_nxt     = ST_RESP;
        end else if (hv) begin
          row_rd_en   = 1'b1;
          row_rd_addr = hc;
          state_nxt   = ST_OLD;
        end else begin
          row_rd_en = 1'b1;
          state_nxt = ST_NEW;
        end
      end
      ST_OLD: begin
        // Old and new rows differ here, so the write and the read do not collide.
        row_wr.en   = 1'b1;
        row_wr.addr = hc;
        row_wr.data = row_mod;
        row_rd_en   = 1'b1;
        state_nxt   = ST_NEW;
      end
      ST_NEW: begin
        home_wr.en    = 1'b1;
        home_wr.addr  = pid_r[PID_AW-1:0];
        resp_cell_nxt = 1'b1;
        state_nxt     = ST_RESP;
        if (!present && !free_found) begin
          home_wr.data = '0;
          resp_sts_nxt = STS_FULL;
        end else begin
          home_wr.data = {1'b1, lin_a};
          resp_sts_nxt = STS_MOVED;
          if (!present) begin
            row_wr.en             = 1'b1;
            row_wr.addr           = lin_a;
            row_wr.data           = row_rd_data;
            row_wr.data[free_idx] = my_slot;
          end
        end
      end
      ST_GRD: begin
        if (nb_ok) begin
          row_rd_en   = 1'b1;
          row_rd_addr = nb_lin[CELL_W-1:0];
          s_nxt       = '0;
          state_nxt   = pass_r ? ST_GEMIT : ST_GCNT;
        end else begin
          do_adv = 1'b1;
        end
      end
      ST_GCNT: begin
        total_nxt = tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];
        do_adv    = 1'b1;
      end
      ST_GEMIT: begin
        if (cur_slot[ID_W]) begin
          if (out_free) begin
            push       = 1'b1;
            push_sts   = STS_NBR;
            push_id    = cur_slot[ID_W-1:0];
            push_gat   = 1'b1;
            push_last  = (emit_n_r + TOT_W'(1) == emit_lim);
            emit_n_nxt = emit_n_r + TOT_W'(1);
            if (push_last) begin
              state_nxt = ST_IDLE;
            end else if (s_r == SIDX_W'(SLOTS_PER_CELL - 1)) begin
              do_adv = 1'b1;
            end else begin
              s_nxt = s_r + SIDX_W'(1);
            end
          end
        end else if (s_r == SIDX_W'(SLOTS_PER_CELL - 1)) begin
          do_adv = 1'b1;
        end else begin
          s_nxt = s_r + SIDX_W'(1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          push      = 1'b1;
          push_cell = resp_cell_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (do_adv) begin
      d_i_nxt = inc_i;
      d_j_nxt = inc_j;
      d_k_nxt = inc_k;
      if (!nb_end) begin
        state_nxt = ST_GRD;
      end else if (!pass_r) begin
        if (total_nxt == '0) begin
          resp_sts_nxt  = STS_NONE;
          resp_cell_nxt = 1'b0;
          state_nxt     = ST_RESP;
        end else begin
          pass_nxt  = 1'b1;
          state_nxt = ST_GRD;
        end
      end else begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_i_r       <= d_i_nxt;
    d_j_r       <= d_j_nxt;
    d_k_r       <= d_k_nxt;
    pass_r      <= pass_nxt;
    total_r     <= total_nxt;
    emit_n_r    <= emit_n_nxt;
    s_r         <= s_nxt;
    resp_sts_r  <= resp_sts_nxt;
    resp_cell_r <= resp_cell_nxt;
    if (push) begin
      out_data_r <= {7'd0,
                     push_gat ? trunc : 1'b0,
                     push_gat ? total_r : TOT_W'(0),
                     push_cell ? map_res.ck : 12'd0,
                     push_cell ? map_res.cj : 12'd0,
                     push_cell ? map_res.ci : 12'd0,
                     push_id};
      out_user_r <= push_sts;
      out_last_r <= push_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

FILE: rtl/core/pcl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "particle_cell_list_macros.svh"
module pcl_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);
  import pcl_pkg::*;

  // A stalled result keeps its content.
  `PCL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // Only one item is in work: a transfer in closes the input side.
  `PCL_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready)

  // Every update result is the only result of its item.
  `PCL_ASSERT_SAME(a_upd_last, out_tvalid && (out_tuser == STS_MOVED ||
                   out_tuser == STS_SAME || out_tuser == STS_OUT || out_tuser == STS_FULL),
                   out_tlast)

  // An empty gather gives one closing result with no payload.
  `PCL_ASSERT_SAME(a_none_clean, out_tvalid && out_tuser == STS_NONE,
                   out_tlast && out_tdata == 64'd0)

endmodule

bind particle_cell_list pcl_props u_pcl_props (.*);
`default_nettype wire

FILE: tb/pcl_checker.sv
`timescale 1ns / 1ps
module pcl_checker
  import pcl_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [143:0] in_tdata,
  input  wire logic         in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [63:0]  out_tdata,
  input  wire logic [2:0]   out_tuser,
  input  wire logic         out_tlast,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] nbr_id;
    logic [11:0] ci;
    logic [11:0] cj;
    logic [11:0] ck;
    logic [7:0]  total;
    logic        trunc;
    logic        last;
  } cell_result_t;

  cell_result_t result_queue[$];

  longint org_x, org_y, org_z, inv_len, ncx, ncy, ncz;
  logic [12:0] slots[MAX_CELLS*SLOTS_PER_CELL];
  logic [16:0] home[MAX_PARTICLES];

  function automatic longint axis_to_cell(logic [31:0] pos, longint org);
    longint diff, mag, ip;
    diff = longint'($signed(pos)) - org;
    mag = diff < 0 ? -diff : diff;
    ip = longint'((64'(mag) * 64'(inv_len)) >> 32);
    return diff < 0 ? 1 - ip : ip + 1;
  endfunction

  function automatic longint linear_cell(longint i, longint j, longint k);
    longint lin;
    if (i < 0 || j < 0 || k < 0) return -1;
    if (i >= ncx || j >= ncy || k >= ncz) return -1;
    if (i > 4095 || j > 4095 || k > 4095) return -1;
    lin = i + j * ncx + k * ncx * ncy;
    if (lin >= MAX_CELLS) return -1;
    return lin;
  endfunction

  task automatic push(logic [2:0] st, logic [11:0] id, longint ci, longint cj, longint ck,
                      logic [7:0] tot, logic tr, logic lst);
    cell_result_t r;
    r = '{st, id, ci[11:0], cj[11:0], ck[11:0], tot, tr, lst};
    result_queue.push_back(r);
  endtask

  task automatic apply_update(logic [143:0] d);
    logic [11:0] id;
    longint ci, cj, ck, lin;
    int freeslot;
    bit present;
    id = d[11:0];
    ci = axis_to_cell(d[43:12], org_x);
    cj = axis_to_cell(d[75:44], org_y);
    ck = axis_to_cell(d[107:76], org_z);
    lin = linear_cell(ci, cj, ck);
    freeslot = SLOTS_PER_CELL;
    present = 0;
    if (lin < 0) begin
      push(STS_OUT, 0, 0, 0, 0, 0, 0, 1);
      return;
    end
    if (home[id][16] && home[id][15:0] == lin[15:0]) begin
      push(STS_SAME, 0, ci, cj, ck, 0, 0, 1);
      return;
    end
    if (home[id][16])
      for (int s = 0; s < SLOTS_PER_CELL; s++)
        if (slots[home[id][15:0]*SLOTS_PER_CELL+s] == {1'b1, id})
          slots[home[id][15:0]*SLOTS_PER_CELL+s] = '0;
    home[id] = '0;
    for (int s = 0; s < SLOTS_PER_CELL; s++) begin
      if (slots[lin*SLOTS_PER_CELL+s] == {1'b1, id}) present = 1;
      if (!slots[lin*SLOTS_PER_CELL+s][12] && freeslot == SLOTS_PER_CELL) freeslot = s;
    end
    if (!present) begin
      if (freeslot == SLOTS_PER_CELL) begin
        push(STS_FULL, 0, ci, cj, ck, 0, 0, 1);
        return;
      end
      slots[lin*SLOTS_PER_CELL+freeslot] = {1'b1, id};
    end
    home[id] = {1'b1, lin[15:0]};
    push(STS_MOVED, 0, ci, cj, ck, 0, 0, 1);
  endtask

  task automatic apply_gather(logic [143:0] d);
    longint qi, qj, qk, lin;
    int total, n;
    logic [11:0] ids[$];
    qi = d[119:108];
    qj = d[131:120];
    qk = d[143:132];
    total = 0;
    for (int dk = -1; dk <= 1; dk++)
      for (int dj = -1; dj <= 1; dj++)
        for (int di = -1; di <= 1; di++) begin
          lin = linear_cell(qi + di, qj + dj, qk + dk);
          if (lin >= 0)
            for (int s = 0; s < SLOTS_PER_CELL; s++)
              if (slots[lin*SLOTS_PER_CELL+s][12]) begin
                total++;
                ids.push_back(slots[lin*SLOTS_PER_CELL+s][11:0]);
              end
        end
    if (total == 0) begin
      push(STS_NONE, 0, 0, 0, 0, 0, 0, 1);
      return;
    end
    n = total > MAX_EMIT ? MAX_EMIT : total;
    for (int e = 0; e < n; e++)
      push(STS_NBR, ids[e], 0, 0, 0, total > 255 ? 8'd255 : 8'(total),
           total > MAX_EMIT, e == n - 1);
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending = result_queue.size();

  initial begin
    fail_count = 0;
    for (int a = 0; a < MAX_CELLS*SLOTS_PER_CELL; a++) slots[a] = '0;
    for (int a = 0; a < MAX_PARTICLES; a++) home[a] = '0;
    org_x = 0; org_y = 0; org_z = 0; inv_len = 65536; ncx = 1; ncy = 1; ncz = 1;
  end

  always @(posedge clk) begin
    cell_result_t e;
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        case (cfg_index)
          CFG_ORIGIN_X: org_x = longint'($signed(cfg_data));
          CFG_ORIGIN_Y: org_y = longint'($signed(cfg_data));
          CFG_ORIGIN_Z: org_z = longint'($signed(cfg_data));
          CFG_INV_LEN:  inv_len = cfg_data;
          CFG_CELLS_X:  ncx = cfg_data[12:0];
          CFG_CELLS_Y:  ncy = cfg_data[12:0];
          CFG_CELLS_Z:  ncz = cfg_data[12:0];
          default: ;
        endcase
      if (out_tvalid && out_tready) begin
        if (result_queue.size() == 0) begin
          $error("unexpected result transfer, status %0d", out_tuser);
          fail_count++;
        end else begin
          e = result_queue.pop_front();
          check_field("status", e.status, out_tuser);
          check_field("result_id", e.nbr_id, out_tdata[11:0]);
          check_field("cell_i", e.ci, out_tdata[23:12]);
          check_field("cell_j", e.cj, out_tdata[35:24]);
          check_field("cell_k", e.ck, out_tdata[47:36]);
          check_field("neighbour_total", e.total, out_tdata[55:48]);
          check_field("truncated", e.trunc, out_tdata[56]);
          check_field("last", e.last, out_tlast);
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser) apply_gather(in_tdata);
        else apply_update(in_tdata);
      end
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import pcl_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           fail_count;
  int           pending;
  int           burst_left;
  int           stall_mode;

  particle_cell_list u_dut (.*);

  pcl_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb: errors");
    $finish;
  end

  // The result side stalls in modes: none, light, heavy.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 3) != 0;
      default: out_tready <= $urandom_range(0, 3) == 0;
    endcase
  end

  // The caller drops cfg_valid after its last write.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] inv, int nx, int ny, int nz);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_INV_LEN, inv);
    write_reg(CFG_CELLS_X, 32'(nx));
    write_reg(CFG_CELLS_Y, 32'(ny));
    write_reg(CFG_CELLS_Z, 32'(nz));
    cfg_valid <= 1'b0;
  endtask

  // It waits for a clock edge first, so the checker has taken the last input transfer.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_item(logic cmd, logic [143:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tuser <= cmd;
    in_tdata <= d;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [143:0] upd(logic [11:0] id, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z);
    return {36'($urandom), z, y, x, id};
  endfunction

  function automatic logic [143:0] gat(logic [11:0] i, logic [11:0] j, logic [11:0] k);
    return {k, j, i, 32'($urandom), 32'($urandom), 32'($urandom), 12'($urandom)};
  endfunction

  // Unit cells, origin 0: [c-1, c) is cell c for c >= 2, else cell 1 or 0.
  function automatic logic [31:0] in_cell(int c);
    return ((c - 1) << 16) | 32'($urandom_range(0, 65535));
  endfunction

  task automatic random_phase(int n, int nx, int ny, int nz, int ids);
    int r;
    for (int t = 0; t < n; t++) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        send_item(1'b0, upd($urandom_range(0, ids - 1), in_cell($urandom_range(0, nx)),
                            in_cell($urandom_range(0, ny)), in_cell($urandom_range(0, nz))));
      else if (r < 90)
        send_item(1'b1, gat($urandom_range(0, nx), $urandom_range(0, ny),
                            $urandom_range(0, nz)));
      else
        send_item($urandom_range(0, 1), {$urandom, $urandom, $urandom, $urandom, $urandom});
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ORIGIN_X;
    cfg_data = '0;
    out_tready = 1'b1;
    stall_mode = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset grid of one cell, then a 4x4x4 grid.
    send_item(1'b0, upd(12'd0, 32'h0, 32'h0, 32'h0));
    send_item(1'b0, upd(12'd0, 32'h0, 32'h0, 32'h0));
    send_item(1'b0, upd(12'hFFF, 32'h8000_0000, 32'h0, 32'h0));
    send_item(1'b1, gat(0, 0, 0));
    send_item(1'b1, gat(12'hFFF, 12'hFFF, 12'hFFF));
    wait_drained();
    set_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 4, 4, 4);
    // Fill one cell past its slot count, then repeat the mover and gather.
    for (int p = 0; p < 10; p++) send_item(1'b0, upd(p, in_cell(2), in_cell(2), in_cell(2)));
    send_item(1'b0, upd(12'd3, in_cell(3), in_cell(2), in_cell(2)));
    send_item(1'b0, upd(12'd9, in_cell(2), in_cell(2), in_cell(2)));
    send_item(1'b0, upd(12'd1, 32'h7FFF_FFFF, in_cell(1), in_cell(1)));
    send_item(1'b0, upd(12'd1, 32'hFFFF_0000, in_cell(1), in_cell(1)));
    send_item(1'b1, gat(2, 2, 2));
    send_item(1'b1, gat(0, 0, 0));
    send_item(1'b1, gat(3, 3, 3));
    wait_drained();

    // Extreme registers, including negative origins and the largest grid.
    set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF, 4096, 4096, 4096);
    send_item(1'b0, upd(12'd20, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000));
    send_item(1'b0, upd(12'd21, 32'h8000_0100, 32'h7FFF_FFFF, 32'hFFFF_0000));
    send_item(1'b0, upd(12'd22, 32'h0, 32'h0, 32'h0));
    send_item(1'b1, gat(1, 1, 1));
    wait_drained();
    set_grid(32'hFFFF_8000, 32'h0, 32'h0, 32'h0, 1, 1, 1);
    send_item(1'b0, upd(12'd23, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF));
    wait_drained();

    // Random phases with a few dense grids.
    set_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 3, 3, 3);
    random_phase(100, 3, 3, 3, 64);
    set_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 2, 2, 2);
    random_phase(80, 2, 2, 2, 40);
    set_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 16, 8, 4);
    random_phase(80, 16, 8, 4, 200);
    set_grid($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 4096),
             $urandom_range(1, 4096), $urandom_range(1, 4096));
    random_phase(40, 8, 8, 8, 4096);

    wait_drained();
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
